// ===== hdl/tgm_pkg.sv =====
`timescale 1ns / 1ps

package tgm_pkg;

	// Field widths
	localparam int COORD_W = 31;
	localparam int WIDTH_W = 32;
	localparam int SLOT_W  = 6;
	localparam int SEG_W   = 6;
	localparam int RANGE_W = 16;
	localparam int COUNT_W = 7;
	localparam int KCNT_W  = 7;

	// Most segments one range may produce
	localparam logic [KCNT_W-1:0] RESULT_LIMIT = 7'd64;

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_MAP   = 1'b1;

	// Configuration register indexes
	localparam logic REG_STRAND = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	// One exon entry, width precomputed at write time
	typedef struct packed {
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		logic [WIDTH_W-1:0] wd;
	} exon_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SKIP,
		ST_WALK,
		ST_ERR
	} state_t;

endpackage

// ===== hdl/tgm_cmd_if.sv =====
`timescale 1ns / 1ps

interface tgm_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [tgm_pkg::SLOT_W-1:0]    exon_index;
	logic [tgm_pkg::COORD_W-1:0]   exon_start;
	logic [tgm_pkg::COORD_W-1:0]   exon_end;
	logic [tgm_pkg::COORD_W-1:0]   range_start;
	logic [tgm_pkg::COORD_W-1:0]   range_end;

	modport source (
		output valid, command, exon_index, exon_start, exon_end, range_start, range_end,
		input  ready
	);
	modport sink (
		input  valid, command, exon_index, exon_start, exon_end, range_start, range_end,
		output ready
	);
endinterface

interface tgm_seg_if;
	logic                          valid;
	logic                          ready;
	logic [tgm_pkg::COORD_W-1:0]   segment_start;
	logic [tgm_pkg::COORD_W-1:0]   segment_end;
	logic [tgm_pkg::SEG_W-1:0]     segment_number;
	logic [tgm_pkg::RANGE_W-1:0]   range_number;
	logic                          last_segment;
	logic                          out_of_bounds;

	modport source (
		output valid, segment_start, segment_end, segment_number, range_number,
		       last_segment, out_of_bounds,
		input  ready
	);
	modport sink (
		input  valid, segment_start, segment_end, segment_number, range_number,
		       last_segment, out_of_bounds,
		output ready
	);
endinterface

// ===== hdl/transcript_to_genome_mapper.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// cmd       in   valid/ready   command, exon_index, exon_start, exon_end,
//                              range_start, range_end
// seg       out  valid/ready   segment_start, segment_end, segment_number,
//                              range_number, last_segment, out_of_bounds
// cfg       in   cfg_wr_en     cfg_index, cfg_data
//
// A map item walks the exon table twice, one entry per cycle through a
// single table read port while seg is not stalled: a checking pass, then an
// emitting pass; an error ends the checking pass early and gives its item.
// Reset clears control and the range counter; the exon table is not cleared.
// A stalled seg channel holds the walk; cmd is ready only between items.

module transcript_to_genome_mapper #(
	parameter int MAX_EXONS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tgm_cmd_if.sink                      cmd,
	tgm_seg_if.source                    seg,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_index,
	input  logic [tgm_pkg::COUNT_W-1:0]  cfg_data
);

	localparam int AW = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
	localparam int JW = $clog2(MAX_EXONS + 1);
	localparam int CW = (JW > tgm_pkg::COUNT_W) ? JW : tgm_pkg::COUNT_W;

	localparam int CoordW = tgm_pkg::COORD_W;
	localparam int WidW   = tgm_pkg::WIDTH_W;

	tgm_pkg::state_t state_q, state_d;

	// Configuration
	logic                         strand_q;
	logic [tgm_pkg::COUNT_W-1:0]  count_q;

	// Walk registers
	logic [CoordW-1:0]            s_q, s_d, e_q, e_d, s0_q, s0_d, e0_q, e0_d;
	logic [JW-1:0]                j_q, j_d, n_q, n_d;
	logic [tgm_pkg::KCNT_W-1:0]   k_q, k_d;
	logic                         pass_q, pass_d;
	logic [tgm_pkg::RANGE_W-1:0]  rc_q, rc_d, rn_q, rn_d;

	// Exon table
	tgm_pkg::exon_t               mem [MAX_EXONS];
	tgm_pkg::exon_t               rd_q, wr_data;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;

	// Output register
	logic                         out_valid_q;
	logic                         out_load;
	logic [CoordW-1:0]            out_start_d, out_end_d;
	logic                         out_last_d, out_err_d;

	logic                         cmd_fire, map_fire, wr_fire, bad_range, out_free;
	logic                         j_end, w_zero, s_ge, e_ge, lim_hit;
	logic [WidW-1:0]              s_ext, e_ext;
	logic [CW-1:0]                cnt_ext, max_ext, n_full;

	assign cmd.ready = (state_q == tgm_pkg::ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign map_fire  = cmd_fire && (cmd.command == tgm_pkg::CMD_MAP);
	assign wr_fire   = cmd_fire && (cmd.command == tgm_pkg::CMD_WRITE) &&
	                   (CW'(cmd.exon_index) < CW'(MAX_EXONS));
	assign bad_range = (cmd.range_start == '0) || (cmd.range_end == '0) ||
	                   (cmd.range_start > cmd.range_end);
	assign out_free  = !out_valid_q || seg.ready;

	// Clamp the exon count to the table depth
	assign cnt_ext = CW'(count_q);
	assign max_ext = CW'(MAX_EXONS);
	assign n_full  = (cnt_ext < max_ext) ? cnt_ext : max_ext;
	assign n_d     = map_fire ? n_full[JW-1:0] : n_q;

	// Step compares against the current entry
	assign s_ext   = {1'b0, s_q};
	assign e_ext   = {1'b0, e_q};
	assign j_end   = (j_q >= n_q);
	assign w_zero  = (rd_q.wd == '0);
	assign s_ge    = (s_ext >= rd_q.wd);
	assign e_ge    = (e_ext >= rd_q.wd);
	assign lim_hit = (k_q >= tgm_pkg::RESULT_LIMIT);

	// Table write data with width worked out up front
	assign wr_en        = wr_fire;
	assign wr_addr      = AW'(cmd.exon_index);
	assign wr_data.lo   = cmd.exon_start;
	assign wr_data.hi   = cmd.exon_end;
	assign wr_data.wd   = (cmd.exon_end < cmd.exon_start) ? '0 :
	                      ({1'b0, cmd.exon_end} - {1'b0, cmd.exon_start} + WidW'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tgm_pkg::ST_IDLE: begin
				if (map_fire) state_d = bad_range ? tgm_pkg::ST_ERR : tgm_pkg::ST_SKIP;
			end
			tgm_pkg::ST_SKIP: begin
				if (j_end) state_d = tgm_pkg::ST_ERR;
				else if (!(w_zero || s_ge)) state_d = tgm_pkg::ST_WALK;
			end
			tgm_pkg::ST_WALK: begin
				if (j_end) state_d = tgm_pkg::ST_ERR;
				else if (w_zero) state_d = tgm_pkg::ST_WALK;
				else if (lim_hit) state_d = tgm_pkg::ST_ERR;
				else if (!e_ge) begin
					if (!pass_q) state_d = tgm_pkg::ST_SKIP;
					else if (out_free) state_d = tgm_pkg::ST_IDLE;
				end
			end
			tgm_pkg::ST_ERR: begin
				if (out_free) state_d = tgm_pkg::ST_IDLE;
			end
			default: state_d = tgm_pkg::ST_IDLE;
		endcase
	end

	// Datapath and output loads
	always_comb begin
		s_d = s_q; e_d = e_q; s0_d = s0_q; e0_d = e0_q;
		j_d = j_q; k_d = k_q; pass_d = pass_q;
		rc_d = rc_q; rn_d = rn_q;
		out_load = 1'b0;
		out_start_d = '0; out_end_d = '0;
		out_last_d = 1'b0; out_err_d = 1'b0;
		unique case (state_q)
			tgm_pkg::ST_IDLE: begin
				if (wr_fire) rc_d = '0;
				if (map_fire) begin
					s_d = cmd.range_start - CoordW'(1);
					e_d = cmd.range_end - CoordW'(1);
					s0_d = cmd.range_start - CoordW'(1);
					e0_d = cmd.range_end - CoordW'(1);
					j_d = '0; k_d = '0; pass_d = 1'b0;
					rn_d = rc_q;
					rc_d = rc_q + tgm_pkg::RANGE_W'(1);
				end
			end
			tgm_pkg::ST_SKIP: begin
				// Drop whole exons ahead of the range start
				if (!j_end && (w_zero || s_ge)) begin
					s_d = CoordW'(s_ext - rd_q.wd);
					e_d = CoordW'(e_ext - rd_q.wd);
					j_d = j_q + JW'(1);
				end
			end
			tgm_pkg::ST_WALK: begin
				if (!j_end && w_zero) begin
					j_d = j_q + JW'(1);
				end else if (!j_end && !lim_hit) begin
					if (e_ge) begin
						// Segment runs to the end of this exon
						if (!pass_q || out_free) begin
							out_load = pass_q;
							out_start_d = strand_q ? rd_q.lo : (rd_q.lo + s_q);
							out_end_d   = strand_q ? (rd_q.hi - s_q) : rd_q.hi;
							k_d = k_q + tgm_pkg::KCNT_W'(1);
							s_d = '0;
							e_d = CoordW'(e_ext - rd_q.wd);
							j_d = j_q + JW'(1);
						end
					end else if (!pass_q) begin
						// Range fits: rewind and emit
						s_d = s0_q; e_d = e0_q;
						j_d = '0; k_d = '0; pass_d = 1'b1;
					end else if (out_free) begin
						out_load = 1'b1;
						out_last_d = 1'b1;
						out_start_d = strand_q ? (rd_q.hi - e_q) : (rd_q.lo + s_q);
						out_end_d   = strand_q ? (rd_q.hi - s_q) : (rd_q.lo + e_q);
					end
				end
			end
			tgm_pkg::ST_ERR: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last_d = 1'b1;
					out_err_d = 1'b1;
					k_d = '0;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgm_pkg::ST_IDLE;
			strand_q <= 1'b0;
			count_q <= tgm_pkg::COUNT_W'(1);
			j_q <= '0;
			n_q <= '0;
			k_q <= '0;
			pass_q <= 1'b0;
			rc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					tgm_pkg::REG_STRAND: strand_q <= cfg_data[0];
					tgm_pkg::REG_COUNT:  count_q <= cfg_data;
					default: ;
				endcase
			end
			j_q <= j_d;
			n_q <= n_d;
			k_q <= k_d;
			pass_q <= pass_d;
			rc_q <= rc_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (seg.ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		s_q <= s_d;
		e_q <= e_d;
		s0_q <= s0_d;
		e0_q <= e0_d;
		rn_q <= rn_d;
		if (out_load) begin
			seg.segment_start  <= out_start_d;
			seg.segment_end    <= out_end_d;
			seg.segment_number <= out_err_d ? '0 : k_q[tgm_pkg::SEG_W-1:0];
			seg.range_number   <= rn_q;
			seg.last_segment   <= out_last_d;
			seg.out_of_bounds  <= out_err_d;
		end
	end

	// Exon table: one write port, one registered read at the next walk index
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[j_d[AW-1:0]];
	end

	assign seg.valid = out_valid_q;

endmodule
